@@ rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// checked only out of reset
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_RST(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ rtl/tbq_pkg.sv @@
// shared types and constants of the terminal byte queue
package tbq_pkg;

  localparam int unsigned INPUT_DEPTH  = 256;
  localparam int unsigned OUTPUT_DEPTH = 256;

  localparam int unsigned IN_IDX_W  = $clog2(INPUT_DEPTH);
  localparam int unsigned IN_CNT_W  = $clog2(INPUT_DEPTH + 1);
  localparam int unsigned OUT_IDX_W = $clog2(OUTPUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUTPUT_DEPTH + 1);

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FILL_W     = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_AT    = 8'h40;
  localparam logic [BYTE_W-1:0] CH_QMARK = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_CARET = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_BSLSH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_SUB   = 8'h1A;

  typedef enum logic [1:0] {
    FUNC_RX    = 2'd0,
    FUNC_WR    = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_FLUSH = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    SIG_NONE = 2'd0,
    SIG_INT  = 2'd1,
    SIG_QUIT = 2'd2,
    SIG_SUSP = 2'd3
  } sig_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ECHO      = 3'd0,
    CFG_CTL_ECHO  = 3'd1,
    CFG_SIG       = 3'd2,
    CFG_INT_CHAR  = 3'd3,
    CFG_QUIT_CHAR = 3'd4,
    CFG_SUSP_CHAR = 3'd5
  } cfg_idx_e;

  // classified word handed from front to back
  typedef struct packed {
    func_e             func;
    logic [BYTE_W-1:0] data;
    logic [1:0]        echo_n;  // echo byte count; a write with no room echoes none
    logic [BYTE_W-1:0] tail;    // second byte of a caret pair
    sig_e              sig;
  } cmd_t;

endpackage

@@ rtl/tbq_cmd_fifo.sv @@
// short queue of classified words between front and back
module tbq_cmd_fifo import tbq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t pop_data_o,
  output logic empty_o
);

  cmd_t                 entries_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_CNT_W-1:0] count_q;

  assign full_o     = (count_q == CMD_CNT_W'(CMD_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/tbq_front.sv @@
// front end: config registers, word intake and echo/signal classification
module tbq_front import tbq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            func_i,
  input  logic [BYTE_W-1:0]     data_byte_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output cmd_t                  q_data_o
);

  logic              echo_q, ctl_echo_q, sig_en_q;
  logic [BYTE_W-1:0] int_char_q, quit_char_q, susp_char_q;
  logic              is_ctl;
  func_e             func;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q      <= 1'b1;
      ctl_echo_q  <= 1'b1;
      sig_en_q    <= 1'b1;
      int_char_q  <= CH_DEL;
      quit_char_q <= CH_BSLSH;
      susp_char_q <= CH_SUB;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ECHO:      echo_q      <= cfg_data_i[0];
        CFG_CTL_ECHO:  ctl_echo_q  <= cfg_data_i[0];
        CFG_SIG:       sig_en_q    <= cfg_data_i[0];
        CFG_INT_CHAR:  int_char_q  <= cfg_data_i[BYTE_W-1:0];
        CFG_QUIT_CHAR: quit_char_q <= cfg_data_i[BYTE_W-1:0];
        CFG_SUSP_CHAR: susp_char_q <= cfg_data_i[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign func       = func_e'(func_i);
  assign is_ctl     = (data_byte_i < CH_SPACE) || (data_byte_i == CH_DEL);

  always_comb begin
    q_data_o.func = func;
    q_data_o.data = data_byte_i;
    q_data_o.tail = (data_byte_i == CH_DEL) ? CH_QMARK : data_byte_i + CH_AT;

    if (!echo_q) begin
      q_data_o.echo_n = 2'd0;
    end else if (is_ctl) begin
      q_data_o.echo_n = ctl_echo_q ? 2'd2 : 2'd0;
    end else begin
      q_data_o.echo_n = 2'd1;
    end

    // interrupt over quit over suspend; written bytes never signal
    q_data_o.sig = SIG_NONE;
    if (func == FUNC_RX && sig_en_q) begin
      priority if (data_byte_i == int_char_q) begin
        q_data_o.sig = SIG_INT;
      end else if (data_byte_i == quit_char_q) begin
        q_data_o.sig = SIG_QUIT;
      end else if (data_byte_i == susp_char_q) begin
        q_data_o.sig = SIG_SUSP;
      end
    end
  end

endmodule

@@ rtl/tbq_back.sv @@
// back end: both byte rings, output memory and the result sequencer
module tbq_back import tbq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  input  cmd_t              q_data_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic              out_valid_o,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic [1:0]        signal_code_o,
  output logic              accepted_o,
  output logic [FILL_W-1:0] input_fill_o,
  output logic [FILL_W-1:0] output_fill_o,
  output logic              data_ready_o,
  output logic              last_o
);

  typedef enum logic [1:0] {S_IDLE, S_FIRST, S_SECOND} state_e;

  state_e                state_q;
  cmd_t                  cmd_q;
  logic [1:0]            n_q;
  logic                  acc_q;
  logic [BYTE_W-1:0]     rd_q;

  logic [BYTE_W-1:0]     in_mem  [INPUT_DEPTH];
  logic [BYTE_W-1:0]     out_mem [OUTPUT_DEPTH];
  logic [IN_IDX_W-1:0]   in_widx_q;
  logic [IN_CNT_W-1:0]   in_occ_q;
  logic [OUT_IDX_W-1:0]  out_widx_q, out_ridx_q;
  logic [OUT_CNT_W-1:0]  out_occ_q;

  logic in_room, out_room, out_any, second;

  assign in_room  = (in_occ_q < IN_CNT_W'(INPUT_DEPTH));
  assign out_room = (out_occ_q < OUT_CNT_W'(OUTPUT_DEPTH));
  assign out_any  = (out_occ_q != '0);
  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i;

  // ring memories
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_data_i.func == FUNC_RX && in_room) begin
      in_mem[in_widx_q] <= q_data_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_data_i.func == FUNC_WR && out_room) begin
      out_mem[out_widx_q] <= q_data_i.data;
    end
    if (q_pop_o && q_data_i.func == FUNC_TICK) begin
      rd_q <= out_mem[out_ridx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      n_q        <= 2'd0;
      acc_q      <= 1'b0;
      in_widx_q  <= '0;
      in_occ_q   <= '0;
      out_widx_q <= '0;
      out_ridx_q <= '0;
      out_occ_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (q_pop_o) begin
            state_q <= S_FIRST;
            unique case (q_data_i.func)
              FUNC_RX: begin
                acc_q <= in_room;
                n_q   <= q_data_i.echo_n;
                if (in_room) begin
                  in_widx_q <= (in_widx_q == IN_IDX_W'(INPUT_DEPTH - 1)) ?
                               '0 : in_widx_q + 1'b1;
                  in_occ_q  <= in_occ_q + 1'b1;
                end
              end
              FUNC_WR: begin
                acc_q <= out_room;
                n_q   <= out_room ? q_data_i.echo_n : 2'd0;
                if (out_room) begin
                  out_widx_q <= (out_widx_q == OUT_IDX_W'(OUTPUT_DEPTH - 1)) ?
                                '0 : out_widx_q + 1'b1;
                  out_occ_q  <= out_occ_q + 1'b1;
                end
              end
              FUNC_TICK: begin
                acc_q <= 1'b0;
                n_q   <= out_any ? 2'd1 : 2'd0;
                if (out_any) begin
                  out_ridx_q <= (out_ridx_q == OUT_IDX_W'(OUTPUT_DEPTH - 1)) ?
                                '0 : out_ridx_q + 1'b1;
                  out_occ_q  <= out_occ_q - 1'b1;
                end
              end
              FUNC_FLUSH: begin
                acc_q      <= 1'b0;
                n_q        <= 2'd0;
                in_widx_q  <= '0;
                in_occ_q   <= '0;
                out_widx_q <= '0;
                out_ridx_q <= '0;
                out_occ_q  <= '0;
              end
            endcase
          end
        end
        S_FIRST: begin
          if (res_ready_i) begin
            state_q <= (n_q == 2'd2) ? S_SECOND : S_IDLE;
          end
        end
        S_SECOND: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result fields come straight from registers and hold while stalled
  assign second        = (state_q == S_SECOND);
  assign res_valid_o   = (state_q != S_IDLE);
  assign last_o        = second || (n_q != 2'd2);
  assign out_valid_o   = (n_q != 2'd0);
  assign signal_code_o = last_o ? cmd_q.sig : SIG_NONE;
  assign accepted_o    = acc_q;
  assign input_fill_o  = FILL_W'(in_occ_q);
  assign output_fill_o = FILL_W'(out_occ_q);
  assign data_ready_o  = (in_occ_q != '0);

  always_comb begin
    priority if (n_q == 2'd0) begin
      out_byte_o = '0;
    end else if (second) begin
      out_byte_o = cmd_q.tail;
    end else if (n_q == 2'd2) begin
      out_byte_o = CH_CARET;
    end else if (cmd_q.func == FUNC_TICK) begin
      out_byte_o = rd_q;
    end else begin
      out_byte_o = cmd_q.data;
    end
  end

endmodule

@@ rtl/terminal_byte_queue_with_echo.sv @@
// top level of the terminal byte queue with echo
//
// words enter on the in channel (in_valid_i / in_ready_o) as a function code and
// a byte: receive, write, transmit tick or flush. each word gives one or two
// result words on the res channel (res_valid_o / res_ready_i); last_o marks the
// final one. a control byte echoed as a caret pair gives two results, caret first
// an accepted word is pushed into the queue; the back end pops it into its
// command register only while idle, doing the ring update and the output memory
// read as it pops, then presents its results from S_FIRST and, for a caret tail,
// S_SECOND, moving on as res_ready_i takes each; it pops no new word until the
// last result of the current one is taken
// a two word queue sits between intake and the back end, so intake keeps going
// while a result waits on a stalled receiver; once the queue fills, in_ready_o
// drops until the receiver takes results again
// reset empties both rings and the queue and loads the default echo and signal
// settings; config writes (cfg_we_i) take effect at once and are meant for idle
`include "assert_macros.svh"
module terminal_byte_queue_with_echo import tbq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            func_i,
  input  logic [BYTE_W-1:0]     data_byte_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic                  out_valid_o,
  output logic [BYTE_W-1:0]     out_byte_o,
  output logic [1:0]            signal_code_o,
  output logic                  accepted_o,
  output logic [FILL_W-1:0]     input_fill_o,
  output logic [FILL_W-1:0]     output_fill_o,
  output logic                  data_ready_o,
  output logic                  last_o
);

  // classified words between front and back
  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wdata, q_rdata;

  tbq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  tbq_cmd_fifo u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .empty_o     (q_empty)
  );

  // rings, echo sequencing and the result port
  tbq_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .q_data_i      (q_rdata),
    .res_valid_o   (res_valid_o),
    .res_ready_i   (res_ready_i),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .signal_code_o (signal_code_o),
    .accepted_o    (accepted_o),
    .input_fill_o  (input_fill_o),
    .output_fill_o (output_fill_o),
    .data_ready_o  (data_ready_o),
    .last_o        (last_o)
  );

  // no result may appear in the cycle after reset is seen low
  `ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |=> !res_valid_o, "result during reset")
  // the caret of a pair is followed right away by its tail
  `ASSERT_RST(a_pair_completes, res_valid_o && res_ready_i && !last_o |=> res_valid_o && last_o, "caret pair broken")
  // a leading result is always a sent caret with no signal
  `ASSERT_RST(a_lead_is_caret, res_valid_o && !last_o |-> out_valid_o && out_byte_o == CH_CARET && signal_code_o == SIG_NONE, "bad lead result")
  // a silent result stands alone and carries a zero byte
  `ASSERT_RST(a_silent_result, res_valid_o && !out_valid_o |-> last_o && out_byte_o == 8'h00, "bad silent result")

endmodule

@@ tb/tbq_checker.sv @@
`timescale 1ns / 100ps
// checker that predicts and compares the result words of the terminal byte queue
module tbq_checker import tbq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [1:0]            func_i,
  input  logic [BYTE_W-1:0]     data_byte_i,
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  logic                  out_valid_i,
  input  logic [BYTE_W-1:0]     out_byte_i,
  input  logic [1:0]            signal_code_i,
  input  logic                  accepted_i,
  input  logic [FILL_W-1:0]     input_fill_i,
  input  logic [FILL_W-1:0]     output_fill_i,
  input  logic                  data_ready_i,
  input  logic                  last_i,
  output int                    fail_count_o,
  output int                    due_count_o
);

  typedef struct packed {
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    sig_e              sig;
    logic              accepted;
    logic [FILL_W-1:0] in_fill;
    logic [FILL_W-1:0] out_fill;
    logic              data_ready;
    logic              last;
  } line_word_t;

  // settings mirrored from the write port
  logic              echo_on, ctl_echo_on, sig_on;
  logic [BYTE_W-1:0] int_ch, quit_ch, susp_ch;

  // received bytes are never read back, so only their count matters
  logic [IN_CNT_W-1:0]  rx_count;
  logic [BYTE_W-1:0]    tx_store [OUTPUT_DEPTH];
  logic [OUT_IDX_W-1:0] tx_head;
  logic [OUT_CNT_W-1:0] tx_count;

  line_word_t words_due[$];
  int         mismatches;

  function automatic void echo_pair(input logic [BYTE_W-1:0] ch, output int n,
                                    output logic [BYTE_W-1:0] first, second);
    n = 0;
    first = '0;
    second = '0;
    if (echo_on) begin
      if (ch < CH_SPACE || ch == CH_DEL) begin
        if (ctl_echo_on) begin
          n = 2;
          first = CH_CARET;
          second = (ch == CH_DEL) ? CH_QMARK : ch + CH_AT;
        end
      end else begin
        n = 1;
        first = ch;
      end
    end
  endfunction

  task automatic predict_words(input func_e f, input logic [BYTE_W-1:0] ch);
    int                   n;
    logic [BYTE_W-1:0]    b0, b1;
    logic                 took;
    sig_e                 sig;
    logic [OUT_IDX_W-1:0] slot;
    line_word_t           w;
    n = 0;
    b0 = '0;
    b1 = '0;
    took = 1'b0;
    sig = SIG_NONE;
    case (f)
      FUNC_RX: begin
        if (rx_count < INPUT_DEPTH) begin
          rx_count++;
          took = 1'b1;
        end
        // a dropped byte is still echoed and matched
        echo_pair(ch, n, b0, b1);
        if (sig_on) begin
          if (ch == int_ch) sig = SIG_INT;
          else if (ch == quit_ch) sig = SIG_QUIT;
          else if (ch == susp_ch) sig = SIG_SUSP;
        end
      end
      FUNC_WR: begin
        if (tx_count < OUTPUT_DEPTH) begin
          slot = tx_head + tx_count[OUT_IDX_W-1:0];
          tx_store[slot] = ch;
          tx_count++;
          took = 1'b1;
          echo_pair(ch, n, b0, b1);
        end
      end
      FUNC_TICK: begin
        if (tx_count != 0) begin
          b0 = tx_store[tx_head];
          tx_head++;
          tx_count--;
          n = 1;
        end
      end
      default: begin
        rx_count = '0;
        tx_head = '0;
        tx_count = '0;
      end
    endcase
    w.in_fill = FILL_W'(rx_count);
    w.out_fill = FILL_W'(tx_count);
    w.data_ready = (rx_count != 0);
    w.accepted = took;
    if (n == 0) begin
      w.out_valid = 1'b0;
      w.out_byte = '0;
      w.sig = sig;
      w.last = 1'b1;
      words_due.push_back(w);
    end else begin
      for (int k = 0; k < n; k++) begin
        w.out_valid = 1'b1;
        w.out_byte = (k == 0) ? b0 : b1;
        w.last = (k == n - 1);
        w.sig = (k == n - 1) ? sig : SIG_NONE;
        words_due.push_back(w);
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    line_word_t want;
    if (!rst_ni) begin
      echo_on = 1'b1;
      ctl_echo_on = 1'b1;
      sig_on = 1'b1;
      int_ch = CH_DEL;
      quit_ch = CH_BSLSH;
      susp_ch = CH_SUB;
      rx_count = '0;
      tx_head = '0;
      tx_count = '0;
      words_due.delete();
      mismatches = 0;
      fail_count_o <= 0;
      due_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ECHO:      echo_on = cfg_data_i[0];
          CFG_CTL_ECHO:  ctl_echo_on = cfg_data_i[0];
          CFG_SIG:       sig_on = cfg_data_i[0];
          CFG_INT_CHAR:  int_ch = cfg_data_i;
          CFG_QUIT_CHAR: quit_ch = cfg_data_i;
          CFG_SUSP_CHAR: susp_ch = cfg_data_i;
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        if (words_due.size() == 0) begin
          mismatches++;
          $display("%0t: result word with none expected: expected nothing, actual byte %0d",
                   $time, out_byte_i);
        end else begin
          want = words_due.pop_front();
          check_field("out_valid", want.out_valid, out_valid_i);
          check_field("out_byte", want.out_byte, out_byte_i);
          check_field("signal_code", want.sig, signal_code_i);
          check_field("accepted", want.accepted, accepted_i);
          check_field("input_fill", want.in_fill, input_fill_i);
          check_field("output_fill", want.out_fill, output_fill_i);
          check_field("data_ready", want.data_ready, data_ready_i);
          check_field("last", want.last, last_i);
        end
      end
      if (in_valid_i && in_ready_i) predict_words(func_e'(func_i), data_byte_i);
      fail_count_o <= mismatches;
      due_count_o <= words_due.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// top of the testbench: clock, reset, stimulus and verdict
module tb_top;
  import tbq_pkg::*;

  // write port indexes that the block has to ignore
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int RESET_CYCLES   = 8;
  localparam int DRAIN_CYCLES   = 6;
  localparam int RX_HOLD_CYCLES = 400;  // long receiver stall, fills the word queue

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic [1:0]            func_i = '0;
  logic [BYTE_W-1:0]     data_byte_i = '0;
  logic                  res_ready_i = 1'b0;

  logic                  in_ready_o;
  logic                  res_valid_o;
  logic                  out_valid_o;
  logic [BYTE_W-1:0]     out_byte_o;
  logic [1:0]            signal_code_o;
  logic                  accepted_o;
  logic [FILL_W-1:0]     input_fill_o;
  logic [FILL_W-1:0]     output_fill_o;
  logic                  data_ready_o;
  logic                  last_o;

  int fail_count;
  int due_count;

  // sender burst state and the receiver hold handoff
  int                burst_left = 0;
  bit                gapless = 1'b0;
  int                hold_asks = 0;
  int                hold_seen = 0;
  logic [BYTE_W-1:0] cur_int = CH_DEL;
  logic [BYTE_W-1:0] cur_quit = CH_BSLSH;
  logic [BYTE_W-1:0] cur_susp = CH_SUB;

  always #1 clk_i = ~clk_i;

  terminal_byte_queue_with_echo uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .data_byte_i   (data_byte_i),
    .res_valid_o   (res_valid_o),
    .res_ready_i   (res_ready_i),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .signal_code_o (signal_code_o),
    .accepted_o    (accepted_o),
    .input_fill_o  (input_fill_o),
    .output_fill_o (output_fill_o),
    .data_ready_o  (data_ready_o),
    .last_o        (last_o)
  );

  tbq_checker line_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .func_i        (func_i),
    .data_byte_i   (data_byte_i),
    .res_valid_i   (res_valid_o),
    .res_ready_i   (res_ready_i),
    .out_valid_i   (out_valid_o),
    .out_byte_i    (out_byte_o),
    .signal_code_i (signal_code_o),
    .accepted_i    (accepted_o),
    .input_fill_i  (input_fill_o),
    .output_fill_i (output_fill_o),
    .data_ready_i  (data_ready_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .due_count_o   (due_count)
  );

  // bytes lean toward the signal characters and control codes
  function automatic logic [BYTE_W-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return cur_int;
      1:       return cur_quit;
      2:       return cur_susp;
      3:       return 8'($urandom_range(0, 31));
      4:       return CH_DEL;
      default: return 8'($urandom);
    endcase
  endfunction

  // one word on the in channel; a new burst may start with a gap
  task automatic send_word(input func_e f, input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gapless ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    func_i <= f;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // random operations by weight
  task automatic mix_words(input int count, input int rx_w, input int wr_w,
                           input int tick_w, input int flush_w);
    int    r;
    func_e f;
    repeat (count) begin
      r = $urandom_range(0, rx_w + wr_w + tick_w + flush_w - 1);
      if (r < rx_w) f = FUNC_RX;
      else if (r < rx_w + wr_w) f = FUNC_WR;
      else if (r < rx_w + wr_w + tick_w) f = FUNC_TICK;
      else f = FUNC_FLUSH;
      // tick and flush carry a don't-care byte
      send_word(f, (f == FUNC_RX || f == FUNC_WR) ? pick_byte() : 8'($urandom));
    end
  endtask

  // stop offering and let every expected result come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_count != 0) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
  endtask

  // all six registers plus one ignored index, written only with the block idle
  task automatic configure(input logic e, input logic c, input logic s,
                           input logic [BYTE_W-1:0] ic, input logic [BYTE_W-1:0] qc,
                           input logic [BYTE_W-1:0] sc);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    // upper data bits of the one-bit registers must be masked off
    write_reg(CFG_ECHO, {7'($urandom), e});
    write_reg(CFG_CTL_ECHO, {7'($urandom), c});
    write_reg(CFG_SIG, {7'($urandom), s});
    write_reg(CFG_INT_CHAR, ic);
    write_reg(CFG_QUIT_CHAR, qc);
    write_reg(CFG_SUSP_CHAR, sc);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 8'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_int = ic;
    cur_quit = qc;
    cur_susp = sc;
    gapless = ($urandom_range(0, 3) == 0);
  endtask

  // receiver: random stall patterns, plus long holds on request
  initial begin : receiver
    logic [15:0] rx_pattern;
    int          rx_mode;
    int          rx_cycle;
    rx_pattern = 16'hFFFF;
    rx_mode = 0;
    rx_cycle = 0;
    forever begin
      @(negedge clk_i);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        res_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
        res_ready_i <= 1'b1;
      end else begin
        if (rx_cycle % 64 == 0) begin
          rx_mode = $urandom_range(0, 3);
          case (rx_mode)
            0:       rx_pattern = 16'hFFFF;                           // no stalls
            2:       rx_pattern = 16'($urandom) | 16'h0001;
            3:       rx_pattern = 16'($urandom & $urandom) | 16'h0001; // mostly stalled
            default: rx_pattern = 16'hFFFF;
          endcase
        end
        if (rx_mode == 1) res_ready_i <= 1'($urandom);
        else res_ready_i <= rx_pattern[rx_cycle % 16];
        rx_cycle++;
      end
    end
  end

  initial begin : stimulus
    logic [BYTE_W-1:0] same_ch;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part under the reset settings
    send_word(FUNC_TICK, 8'h00);   // tick with nothing queued
    send_word(FUNC_RX, 8'h00);     // caret pair ^@
    send_word(FUNC_RX, 8'h1F);
    send_word(FUNC_RX, CH_SPACE);  // lowest printable byte
    send_word(FUNC_RX, CH_DEL);    // ^? and interrupt
    send_word(FUNC_RX, CH_BSLSH);  // quit, printable
    send_word(FUNC_RX, CH_SUB);    // ^Z and suspend
    send_word(FUNC_RX, 8'h7E);
    send_word(FUNC_RX, 8'hFF);
    send_word(FUNC_RX, 8'h80);
    send_word(FUNC_WR, 8'h00);
    send_word(FUNC_WR, CH_DEL);
    send_word(FUNC_WR, 8'hFF);
    send_word(FUNC_WR, 8'h41);
    send_word(FUNC_WR, CH_BSLSH);  // written bytes raise no signal
    repeat (6) send_word(FUNC_TICK, 8'hFF);  // drain the output ring and tick once more
    send_word(FUNC_FLUSH, 8'hA5);
    send_word(FUNC_RX, 8'h41);
    send_word(FUNC_FLUSH, 8'h00);

    // mixed traffic with a long receiver hold, then a full pause
    configure(1'b1, 1'b1, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
    hold_asks++;
    gapless = 1'b1;
    mix_words(40, 45, 30, 20, 5);
    gapless = 1'b0;
    wait_drained();
    mix_words(40, 45, 30, 20, 5);

    // fill the input ring past full: drops still echo and signal
    configure(1'b1, 1'b1, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
    send_word(FUNC_FLUSH, 8'($urandom));
    mix_words(262, 100, 0, 0, 0);

    // echo off, control echo off, signals off
    configure(1'b0, 1'b1, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
    mix_words(30, 45, 30, 20, 5);
    configure(1'b1, 1'b0, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
    mix_words(30, 45, 30, 20, 5);
    configure(1'b1, 1'b1, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    mix_words(30, 45, 30, 20, 5);

    // signal priority with equal characters, extremes of the character range
    same_ch = 8'($urandom);
    configure(1'b1, 1'b1, 1'b1, same_ch, same_ch, same_ch);
    mix_words(30, 60, 20, 15, 5);
    configure(1'b1, 1'b1, 1'b1, 8'h00, 8'hFF, 8'hFF);
    mix_words(30, 60, 20, 15, 5);
    configure(1'b1, 1'b0, 1'b1, 8'hFF, 8'h00, 8'hFF);
    mix_words(30, 60, 20, 15, 5);

    // fill the output ring past full, then tick it down so the read index wraps
    configure(1'b1, 1'b1, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
    send_word(FUNC_FLUSH, 8'($urandom));
    mix_words(258, 0, 100, 0, 0);
    mix_words(285, 0, 8, 92, 0);

    configure(1'b0, 1'b0, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    mix_words(30, 45, 30, 20, 5);

    // wait out the last results and catch any stray word
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin : watchdog
    #(1_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tbq_pkg.sv
rtl/tbq_cmd_fifo.sv
rtl/tbq_front.sv
rtl/tbq_back.sv
rtl/terminal_byte_queue_with_echo.sv
tb/tbq_checker.sv
tb/tb_top.sv
